// ===== rtl/lprle_pkg.sv =====
// Shared types for the lossy pixel run-length encoder.
package lprle_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned DIST_W  = 18;

   // Register indexes on the configuration port, one 32-bit word apart.
   localparam logic REG_DISTANCE_THRESHOLD = 1'b0;
   localparam logic REG_MAX_RUN            = 1'b1;

   typedef struct packed {
      logic [DIST_W-1:0]  distance_threshold;
      logic [COUNT_W-1:0] max_run;
   } cfg_type;

   // One command from the classifier: an optional run break record (never
   // the last of a frame) and an optional frame-closing record.
   typedef struct packed {
      logic               brk_valid;
      logic [WORD_W-1:0]  brk_word;
      logic [COUNT_W-1:0] brk_count;
      logic               fin_valid;
      logic [WORD_W-1:0]  fin_word;
      logic [COUNT_W-1:0] fin_count;
   } cmd_type;

endpackage

// ===== rtl/lprle_front.sv =====
// Classifier: run state, byte distance test and command generation.
module lprle_front (
   input  logic                clock,
   input  logic                reset,
   input  lprle_pkg::cfg_type  cfg,
   input  logic                in_valid,
   input  logic [31:0]         pixel_word,
   input  logic                frame_end,
   output logic                cmd_push,
   output lprle_pkg::cmd_type  cmd
);
   import lprle_pkg::*;

   logic [WORD_W-1:0]  open_word_ff, open_word_in;
   logic [COUNT_W-1:0] run_len_ff, run_len_in;
   logic               frame_start_ff, frame_start_in;

   logic [WORD_W-1:0]  cur_open;
   logic [COUNT_W-1:0] cur_len;
   logic [7:0]         diff [4];
   logic [15:0]        sq [4];
   logic [DIST_W-1:0]  sq_sum;
   logic               join_run;
   logic [WORD_W-1:0]  new_open;
   logic [COUNT_W-1:0] new_len;

   always_comb begin
      // The first word of a frame opens its own run with length zero.
      cur_open = frame_start_ff ? pixel_word : open_word_ff;
      cur_len  = frame_start_ff ? '0 : run_len_ff;
      for (int k = 0; k < 4; k++) begin
         diff[k] = (pixel_word[8*k +: 8] > cur_open[8*k +: 8]) ?
                   (pixel_word[8*k +: 8] - cur_open[8*k +: 8]) :
                   (cur_open[8*k +: 8] - pixel_word[8*k +: 8]);
         sq[k]   = diff[k] * diff[k];
      end
      sq_sum = ({2'b00, sq[0]} + {2'b00, sq[1]}) + ({2'b00, sq[2]} + {2'b00, sq[3]});
      join_run = (sq_sum < cfg.distance_threshold) && (cur_len < cfg.max_run);
      new_open = join_run ? cur_open : pixel_word;
      new_len  = join_run ? cur_len + 8'd1 : 8'd1;

      cmd.brk_valid = !join_run;
      cmd.brk_word  = cur_open;
      cmd.brk_count = cur_len;
      cmd.fin_valid = frame_end;
      cmd.fin_word  = new_open;
      cmd.fin_count = new_len;
      cmd_push      = in_valid && (!join_run || frame_end);

      open_word_in   = open_word_ff;
      run_len_in     = run_len_ff;
      frame_start_in = frame_start_ff;
      if (in_valid) begin
         open_word_in   = new_open;
         run_len_in     = frame_end ? '0 : new_len;
         frame_start_in = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_word_ff   <= '0;
         run_len_ff     <= '0;
         frame_start_ff <= 1'b1;
      end else begin
         open_word_ff   <= open_word_in;
         run_len_ff     <= run_len_in;
         frame_start_ff <= frame_start_in;
      end
   end

`ifndef SYNTHESIS
   a_end_opens_frame: assert property (@(posedge clock) disable iff (reset)
      in_valid && frame_end |=> frame_start_ff && run_len_ff == '0)
      else $error("frame end did not rearm frame start");
   a_open_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      !frame_start_ff |-> run_len_ff != '0)
      else $error("open run has zero length inside a frame");
   a_push_has_record: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> cmd.brk_valid || cmd.fin_valid)
      else $error("command pushed without any record");
`endif
endmodule

// ===== rtl/lprle_cmd_queue.sv =====
// Short command queue between the classifier and the record emitter.
module lprle_cmd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lprle_pkg::cmd_type  push_cmd,
   output logic                full,
   input  logic                pop,
   output lprle_pkg::cmd_type  head_cmd,
   output logic                empty
);
   import lprle_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds depth");
   a_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push while queue is full");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with unequal pointers");
`endif
endmodule

// ===== rtl/lprle_back.sv =====
// Record emitter: expands each queued command into one or two records.
module lprle_back (
   input  logic                clock,
   input  logic                reset,
   input  lprle_pkg::cmd_type  head_cmd,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [31:0]         rsp_run_word,
   output logic [7:0]          rsp_run_count,
   output logic                rsp_last_record
);
   import lprle_pkg::*;

   logic phase_ff, phase_in;
   logic sel_fin;
   logic xfer;

   always_comb begin
      // Once the break record has been taken, the frame-closing one follows.
      sel_fin         = !head_cmd.brk_valid || phase_ff;
      rsp_empty       = q_empty;
      rsp_run_word    = sel_fin ? head_cmd.fin_word : head_cmd.brk_word;
      rsp_run_count   = sel_fin ? head_cmd.fin_count : head_cmd.brk_count;
      rsp_last_record = sel_fin;
      xfer            = rsp_pop && !q_empty;
      q_pop           = xfer && (sel_fin || !head_cmd.fin_valid);
      phase_in        = phase_ff;
      if (q_pop) begin
         phase_in = 1'b0;
      end else if (xfer) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

`ifndef SYNTHESIS
   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !q_empty && head_cmd.brk_valid && head_cmd.fin_valid)
      else $error("second record pending without a two-record command");
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff && !rsp_pop |=> phase_ff)
      else $error("pending second record lost while stalled");
`endif
endmodule

// ===== rtl/lossy_pixel_run_length_encoder_unit.sv =====
// Top level of the lossy pixel run-length encoder with its register port.
//
//   channel  | ports                                    | transfer when
//   ---------+------------------------------------------+-------------------------------
//   request  | req_pixel_word, req_frame_end            | req_push && !req_full
//   response | rsp_run_word, rsp_run_count,             | rsp_pop && !rsp_empty
//            | rsp_last_record                          |
//   csr      | csr_paddr, csr_pwdata, csr_prdata        | csr_psel && csr_penable && csr_pwrite
//
// A word is classified in the cycle it is transferred; one word per cycle is accepted
// while the command queue has room. The emitter gives one record per cycle while rsp_pop is high,
// so a word closing a frame after a run break gives a break record and then a closing record.
// Records appear on the response ports once the word's command is registered and at the queue head.
// Reset clears the run state and queue; no clearing pass is needed.
// A stalled response side fills the queue of QUEUE_DEPTH commands, then req_full rises.
module lossy_pixel_run_length_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_pixel_word,
   input  logic        req_frame_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_run_word,
   output logic [7:0]  rsp_run_count,
   output logic        rsp_last_record,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lprle_pkg::*;

   logic [DIST_W-1:0]  thresh_ff, thresh_in;
   logic [COUNT_W-1:0] max_run_ff, max_run_in;
   logic               csr_write;
   logic               reg_sel;
   cfg_type            cfg;
   logic               in_valid;
   logic               cmd_push;
   cmd_type            cmd;
   cmd_type            head_cmd;
   logic               q_empty;
   logic               q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      thresh_in  = thresh_ff;
      max_run_in = max_run_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_DISTANCE_THRESHOLD: thresh_in  = csr_pwdata[DIST_W-1:0];
            REG_MAX_RUN:            max_run_in = csr_pwdata[COUNT_W-1:0];
            default: begin
               thresh_in  = thresh_ff;
               max_run_in = max_run_ff;
            end
         endcase
      end
      case (reg_sel)
         REG_DISTANCE_THRESHOLD: csr_prdata = {{(32-DIST_W){1'b0}}, thresh_ff};
         REG_MAX_RUN:            csr_prdata = {{(32-COUNT_W){1'b0}}, max_run_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= DIST_W'(110);
         max_run_ff <= COUNT_W'(255);
      end else begin
         thresh_ff  <= thresh_in;
         max_run_ff <= max_run_in;
      end
   end

   assign cfg.distance_threshold = thresh_ff;
   assign cfg.max_run            = max_run_ff;
   assign in_valid               = req_push && !req_full;

   lprle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (in_valid),
      .pixel_word (req_pixel_word),
      .frame_end  (req_frame_end),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   lprle_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (req_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   lprle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_run_word    (rsp_run_word),
      .rsp_run_count   (rsp_run_count),
      .rsp_last_record (rsp_last_record)
   );

`ifndef SYNTHESIS
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && reg_sel == REG_MAX_RUN |=> max_run_ff == $past(csr_pwdata[COUNT_W-1:0]))
      else $error("max_run write not applied");
   a_thresh_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && reg_sel == REG_DISTANCE_THRESHOLD
      |=> thresh_ff == $past(csr_pwdata[DIST_W-1:0]))
      else $error("distance_threshold write not applied");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !cmd_push)
      else $error("command generated while queue is full");
`endif
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the lossy pixel run-length encoder unit.
module testbench;
   import lprle_pkg::*;

   localparam logic [2:0] ADDR_DISTANCE_THRESHOLD = {REG_DISTANCE_THRESHOLD, 2'b00};
   localparam logic [2:0] ADDR_MAX_RUN            = {REG_MAX_RUN, 2'b00};
   localparam logic [DIST_W-1:0]  THRESHOLD_MAX  = '1;
   localparam logic [COUNT_W-1:0] RUN_MAX        = '1;
   localparam int unsigned SETTLE_CYCLES         = 8;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              frame_end;
   } pixel_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               last;
   } run_record_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [WORD_W-1:0]  req_pixel_word = '0;
   logic               req_frame_end = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [WORD_W-1:0]  rsp_run_word;
   logic [COUNT_W-1:0] rsp_run_count;
   logic               rsp_last_record;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   lossy_pixel_run_length_encoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_word  (req_pixel_word),
      .req_frame_end   (req_frame_end),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_run_word    (rsp_run_word),
      .rsp_run_count   (rsp_run_count),
      .rsp_last_record (rsp_last_record),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #2 clock = ~clock;

   // Encoder state as the testbench predicts it.
   logic [DIST_W-1:0]  cfg_threshold = 18'd110;
   logic [COUNT_W-1:0] cfg_max_run   = 8'd255;
   logic [WORD_W-1:0]  open_word     = '0;
   logic [COUNT_W-1:0] open_len      = '0;
   logic               frame_opening = 1'b1;

   pixel_item_type pending_words[$];
   run_record_type expected_records[$];
   pixel_item_type next_item;

   int unsigned words_queued    = 0;
   int unsigned words_accepted  = 0;
   int unsigned records_checked = 0;
   int unsigned frames_closed   = 0;
   int unsigned settings_used   = 0;
   int unsigned errors          = 0;
   int unsigned send_gap        = 0;
   int unsigned pop_gap         = 0;
   bit          req_taken       = 1'b0;
   bit          sender_idles    = 1'b1;
   bit          receiver_idles  = 1'b1;

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned squared_byte_distance(input logic [WORD_W-1:0] a,
                                                         input logic [WORD_W-1:0] b);
      int unsigned sum;
      int          d;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
         d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
         sum += d * d;
      end
      return sum;
   endfunction

   // Each byte of the base word moves by at most spread, clamped to a byte.
   function automatic logic [WORD_W-1:0] nudge_word(input logic [WORD_W-1:0] base,
                                                    input int spread);
      logic [WORD_W-1:0] word;
      int                b;
      for (int k = 0; k < 4; k++) begin
         b = int'(base[8*k +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
         if (b < 0) b = 0;
         if (b > 255) b = 255;
         word[8*k +: 8] = b[7:0];
      end
      return word;
   endfunction

   task automatic push_record(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] count,
                              input logic last);
      run_record_type rec;
      rec.word  = word;
      rec.count = count;
      rec.last  = last;
      expected_records.insert(expected_records.size(), rec);
   endtask

   task automatic predict_records(input logic [WORD_W-1:0] word, input logic frame_end);
      if (frame_opening) begin
         open_word     = word;
         open_len      = '0;
         frame_opening = 1'b0;
      end
      if (squared_byte_distance(word, open_word) < cfg_threshold && open_len < cfg_max_run) begin
         open_len = open_len + 1'b1;
      end else begin
         push_record(open_word, open_len, 1'b0);
         open_word = word;
         open_len  = 8'd1;
      end
      // The open run always holds at least the word just taken.
      if (frame_end) begin
         push_record(open_word, open_len, 1'b1);
         open_len      = '0;
         frame_opening = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] expected_value,
                                  input logic [31:0] actual_value);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, expected_value,
               actual_value);
   endtask

   // Monitor: compare each result transfer, then predict from each request transfer.
   always @(posedge clock) begin
      req_taken = !reset && req_push && !req_full;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_records.size() == 0) begin
            report_mismatch("unexpected record word", '0, rsp_run_word);
         end else begin
            if (rsp_run_word !== expected_records[0].word)
               report_mismatch("run_word", expected_records[0].word, rsp_run_word);
            if (rsp_run_count !== expected_records[0].count)
               report_mismatch("run_count", 32'(expected_records[0].count),
                               32'(rsp_run_count));
            if (rsp_last_record !== expected_records[0].last)
               report_mismatch("last_record", 32'(expected_records[0].last),
                               32'(rsp_last_record));
            void'(expected_records.pop_front());
            records_checked++;
         end
      end
      if (req_taken) begin
         predict_records(req_pixel_word, req_frame_end);
         words_accepted++;
         if (req_frame_end) frames_closed++;
      end
   end

   // Driver: a word stays on the ports until its transfer.
   always @(negedge clock) begin
      if (req_push && !req_taken) begin
         // still waiting for the transfer
      end else if (send_gap > 0) begin
         req_push <= 1'b0;
         send_gap--;
      end else if (pending_words.size() != 0) begin
         next_item = pending_words.pop_front();
         req_pixel_word <= next_item.word;
         req_frame_end  <= next_item.frame_end;
         req_push       <= 1'b1;
         send_gap = sender_idles ? gap_len() : 0;
      end else begin
         req_push <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (pop_gap > 0) begin
         rsp_pop <= 1'b0;
         pop_gap--;
      end else begin
         rsp_pop <= 1'b1;
         if (receiver_idles && $urandom_range(0, 3) == 0) pop_gap = gap_len();
      end
   end

   task automatic add_word(input logic [WORD_W-1:0] word, input logic frame_end);
      pixel_item_type item;
      item.word      = word;
      item.frame_end = frame_end;
      pending_words.insert(pending_words.size(), item);
      words_queued++;
   endtask

   task automatic drain_all();
      while (words_accepted != words_queued || expected_records.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register, then read it back.
   task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (addr)
         ADDR_DISTANCE_THRESHOLD: cfg_threshold = value[DIST_W-1:0];
         ADDR_MAX_RUN:            cfg_max_run   = value[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) report_mismatch("register readback", value, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [DIST_W-1:0] threshold,
                            input logic [COUNT_W-1:0] max_run);
      set_register(ADDR_DISTANCE_THRESHOLD, 32'(threshold));
      set_register(ADDR_MAX_RUN, 32'(max_run));
      settings_used++;
   endtask

   // Frames of mostly similar words, with some noise and drifting content.
   task automatic add_random_frames(input int unsigned n_words);
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] word;
      int unsigned       left;
      int unsigned       len;
      int                spread;
      left = n_words;
      while (left > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         if (len > left) len = left;
         base = $urandom();
         case ($urandom_range(0, 5))
            0:       spread = 0;
            1:       spread = 2;
            2:       spread = 5;
            3:       spread = 8;
            4:       spread = 40;
            default: spread = 255;
         endcase
         for (int unsigned k = 0; k < len; k++) begin
            word = nudge_word(base, spread);
            if ($urandom_range(0, 15) == 0) word = $urandom();
            if ($urandom_range(0, 3) == 0) base = word;
            add_word(word, k == len - 1);
         end
         left -= len;
      end
   endtask

   initial begin
      logic [DIST_W-1:0]  threshold;
      logic [COUNT_W-1:0] max_run;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: single-word frame, all-ones words, and the threshold edge.
      add_word(32'h0000_0000, 1'b1);
      add_word(32'hFFFF_FFFF, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b0);
      add_word(32'hFFFF_FFF6, 1'b0);
      add_word(32'h0000_0000, 1'b1);
      add_word(32'h8080_8080, 1'b0);
      add_word(32'h8080_838A, 1'b0);
      add_word(32'h8081_838A, 1'b0);
      add_word(32'h8080_8080, 1'b1);
      drain_all();

      // A zero threshold emits an empty record at the start of each frame.
      configure('0, RUN_MAX);
      add_word(32'h1234_5678, 1'b0);
      add_word(32'h1234_5678, 1'b0);
      add_word(32'h1234_5678, 1'b1);
      drain_all();

      // A zero max_run lets no word join a run.
      configure(18'd110, '0);
      add_word(32'hA5A5_A5A5, 1'b0);
      add_word(32'hA5A5_A5A5, 1'b1);
      add_word(32'h5A5A_5A5A, 1'b1);
      drain_all();

      configure(18'd110, 8'd2);
      repeat (4) add_word(32'hC3C3_C3C3, 1'b0);
      add_word(32'hC3C3_C3C3, 1'b1);
      drain_all();

      // Largest threshold: every word joins, so runs stop at the full count.
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      configure(THRESHOLD_MAX, RUN_MAX);
      for (int k = 0; k < 269; k++) add_word($urandom(), 1'b0);
      add_word($urandom(), 1'b1);
      drain_all();

      for (int p = 0; p < 5; p++) begin
         case ($urandom_range(0, 5))
            0:       threshold = '0;
            1:       threshold = DIST_W'($urandom_range(1, 200));
            2:       threshold = 18'd110;
            3:       threshold = DIST_W'($urandom_range(200, 5000));
            4:       threshold = THRESHOLD_MAX;
            default: threshold = DIST_W'($urandom_range(0, 262143));
         endcase
         case ($urandom_range(0, 4))
            0:       max_run = '0;
            1:       max_run = 8'd1;
            2:       max_run = COUNT_W'($urandom_range(2, 6));
            3:       max_run = RUN_MAX;
            default: max_run = COUNT_W'($urandom_range(0, 255));
         endcase
         sender_idles   = $urandom_range(0, 3) != 0;
         receiver_idles = $urandom_range(0, 3) != 0;
         configure(threshold, max_run);
         add_random_frames(14);
         // The sender holds off here until every record has come back.
         drain_all();
         add_random_frames(14);
         drain_all();
      end

      $display("Run covered %0d pixel words in %0d frames and %0d records", words_accepted,
               frames_closed, records_checked);
      $display("over %0d register settings, with %0d mismatches", settings_used, errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d records still expected", expected_records.size());
      $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lprle_pkg.sv
rtl/lprle_front.sv
rtl/lprle_cmd_queue.sv
rtl/lprle_back.sv
rtl/lossy_pixel_run_length_encoder_unit.sv
tb/testbench.sv
